### rtl/core/prp_pkg.sv
package prp_pkg;

    // field widths
    localparam int FIELD_W = 16;
    localparam int ANGLE_W = FIELD_W + 1;

    localparam int TRIG_FRACTION_BITS = 16;
    localparam int COORD_BITS         = 16;

    // series arithmetic in q30, magnitudes below one, terms up to one
    localparam int Q_FRAC = 30;
    localparam int Q_W    = 30;
    localparam int T_W    = Q_W + 1;
    localparam logic [T_W-1:0] Q_ONE = T_W'(64'd1 << Q_FRAC);

    // constant division by reciprocal multiply, one correction step
    localparam int DIV_W       = 8;
    localparam int REM_W       = DIV_W + 2;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 32;

    localparam int SIN_TERMS   = 5;
    localparam int COS_TERMS   = 6;
    localparam int CELL_STAGES = 3;
    localparam int CHAIN_LAT   = CELL_STAGES * COS_TERMS;
    localparam int SIN_SKEW    = CELL_STAGES * (COS_TERMS - SIN_TERMS);

    localparam logic [DIV_W-1:0] SIN_DIV [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [DIV_W-1:0] COS_DIV [COS_TERMS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    localparam logic [RECIP_W-1:0] SIN_RECIP [SIN_TERMS] = '{
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd110),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd72),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd42),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd20),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd6)
    };
    localparam logic [RECIP_W-1:0] COS_RECIP [COS_TERMS] = '{
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd132),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd90),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd56),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd30),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd12),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd2)
    };

    // angle reduction, units of 1/64 degree
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = FULL_TURN / 4;
    localparam int EIGHTH_TURN  = FULL_TURN / 8;
    localparam int RED_W        = 17;
    localparam int R_W          = 15;
    localparam int F_W          = 13;
    localparam int G_W          = 12;
    localparam int RAD_W        = 19;
    localparam int RAD_PROD_W   = G_W + RAD_W;
    localparam logic [RED_W-1:0] ANG_BIAS     = RED_W'(2 * FULL_TURN);
    localparam logic [RAD_W-1:0] RAD_PER_UNIT = 19'd292818;

    // rounding to the output fraction
    localparam int TRIG_MAG_W  = TRIG_FRACTION_BITS + 1;
    localparam int TRIG_W      = TRIG_MAG_W + 1;
    localparam int ROUND_SHIFT = Q_FRAC - TRIG_FRACTION_BITS;
    localparam logic [T_W-1:0] ROUND_HALF = T_W'(64'd1 << (ROUND_SHIFT - 1));

    localparam int SC_LAT = 4 + CHAIN_LAT + 2;

    // rotation datapath
    localparam int DELTA_W  = FIELD_W + 2;
    localparam int PROD_W   = TRIG_W + DELTA_W;
    localparam int DOT_W    = PROD_W + 1;
    localparam int ROT_W    = DOT_W - TRIG_FRACTION_BITS;
    localparam int POS_W    = ROT_W + 2;
    localparam int SAT_W    = 34;
    localparam logic [DOT_W-1:0] TRUNC_BIAS = DOT_W'((64'd1 << TRIG_FRACTION_BITS) - 64'd1);
    localparam logic signed [SAT_W-1:0] COORD_MAX =
        SAT_W'((longint'(1) <<< (COORD_BITS - 1)) - longint'(1));
    localparam logic signed [SAT_W-1:0] COORD_MIN =
        SAT_W'(-(longint'(1) <<< (COORD_BITS - 1)));

    localparam int PIPE_LAT = SC_LAT + 4;

    typedef logic [Q_W-1:0]           frac_t;
    typedef logic [T_W-1:0]           term_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        trig_t sin_v;
        trig_t cos_v;
    } sincos_t;

endpackage

### rtl/core/prp_series_cell.sv
module prp_series_cell
(
    input  logic                        clk,
    input  logic [prp_pkg::Q_W-1:0]     x2_in,
    input  logic [prp_pkg::T_W-1:0]     t_in,
    input  logic [prp_pkg::DIV_W-1:0]   div,
    input  logic [prp_pkg::RECIP_W-1:0] recip,
    output logic [prp_pkg::Q_W-1:0]     x2_out,
    output logic [prp_pkg::T_W-1:0]     t_out
);
    import prp_pkg::*;

    localparam int AB_W = Q_W + T_W;
    localparam int QR_W = Q_W + RECIP_W;

    logic [AB_W-1:0]  ab_prod;
    logic [QR_W-1:0]  qr_prod;
    logic [REM_W-1:0] rem;
    logic             corr;

    frac_t x2_a_reg, x2_b_reg, x2_c_reg;
    frac_t p_a_reg, p_a_next;
    frac_t p_b_reg;
    frac_t qe_b_reg, qe_b_next;
    term_t t_c_reg, t_c_next;

    always_comb
    begin
        ab_prod  = AB_W'(x2_in) * AB_W'(t_in);
        p_a_next = ab_prod[Q_FRAC +: Q_W];

        // quotient estimate is low by at most one
        qr_prod   = QR_W'(p_a_reg) * QR_W'(recip);
        qe_b_next = qr_prod[RECIP_SHIFT +: Q_W];

        rem      = REM_W'(p_b_reg) - REM_W'(qe_b_reg) * REM_W'(div);
        corr     = (rem >= REM_W'(div));
        t_c_next = Q_ONE - T_W'(qe_b_reg) - T_W'(corr);
    end

    always_ff @(posedge clk)
    begin
        x2_a_reg <= x2_in;
        p_a_reg  <= p_a_next;
        x2_b_reg <= x2_a_reg;
        p_b_reg  <= p_a_reg;
        qe_b_reg <= qe_b_next;
        x2_c_reg <= x2_b_reg;
        t_c_reg  <= t_c_next;
    end

    assign x2_out = x2_c_reg;
    assign t_out  = t_c_reg;

endmodule

### rtl/core/prp_sincos.sv
module prp_sincos
(
    input  logic                              clk,
    input  logic signed [prp_pkg::FIELD_W-1:0] angle,
    output prp_pkg::sincos_t                  sc
);
    import prp_pkg::*;

    localparam int AB_W = Q_W + T_W;
    localparam int SQ_W = 2 * Q_W;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
        frac_t      x;
    } fold_t;

    logic [RED_W-1:0] biased;
    logic [R_W-1:0]   r_reg, r_next;
    logic [F_W-1:0]   f;
    logic [G_W-1:0]   g_reg, g_next;
    logic [1:0]       quad_reg, quad_next;
    logic             swap_reg, swap_next;
    fold_t            fold3_reg, fold3_next;
    fold_t            fold4_reg;
    logic [SQ_W-1:0]  sq;
    frac_t            x2_reg, x2_next;
    fold_t            fold_dly_reg [CHAIN_LAT];
    frac_t            x2_dly_reg [SIN_SKEW];

    frac_t cos_x2 [COS_TERMS+1];
    term_t cos_t  [COS_TERMS+1];
    frac_t sin_x2 [SIN_TERMS+1];
    term_t sin_t  [SIN_TERMS+1];

    logic [AB_W-1:0]       s_prod;
    frac_t                 s_raw_reg, s_raw_next;
    term_t                 c_raw_reg;
    logic [1:0]            quad_o_reg;
    logic                  swap_o_reg;
    term_t                 s_rnd, c_rnd;
    logic [TRIG_MAG_W-1:0] s_mag, c_mag, s0, c0;
    trig_t                 s_pos, c_pos;
    sincos_t               sc_reg, sc_next;

    // reduce to one turn, then to one octant
    always_comb
    begin
        biased = RED_W'(angle) + ANG_BIAS;
        if (biased >= RED_W'(3 * FULL_TURN))
            r_next = R_W'(biased - RED_W'(3 * FULL_TURN));
        else if (biased >= RED_W'(2 * FULL_TURN))
            r_next = R_W'(biased - RED_W'(2 * FULL_TURN));
        else if (biased >= RED_W'(FULL_TURN))
            r_next = R_W'(biased - RED_W'(FULL_TURN));
        else
            r_next = R_W'(biased);

        if (r_reg >= R_W'(3 * QUARTER_TURN))
        begin
            quad_next = QUAD_FOURTH;
            f         = F_W'(r_reg - R_W'(3 * QUARTER_TURN));
        end
        else if (r_reg >= R_W'(2 * QUARTER_TURN))
        begin
            quad_next = QUAD_THIRD;
            f         = F_W'(r_reg - R_W'(2 * QUARTER_TURN));
        end
        else if (r_reg >= R_W'(QUARTER_TURN))
        begin
            quad_next = QUAD_SECOND;
            f         = F_W'(r_reg - R_W'(QUARTER_TURN));
        end
        else
        begin
            quad_next = QUAD_FIRST;
            f         = F_W'(r_reg);
        end

        swap_next = (f > F_W'(EIGHTH_TURN));
        g_next    = swap_next ? G_W'(F_W'(QUARTER_TURN) - f) : G_W'(f);

        fold3_next.quad = quad_reg;
        fold3_next.swap = swap_reg;
        fold3_next.x    = Q_W'(RAD_PROD_W'(g_reg) * RAD_PROD_W'(RAD_PER_UNIT));

        sq      = SQ_W'(fold3_reg.x) * SQ_W'(fold3_reg.x);
        x2_next = sq[Q_FRAC +: Q_W];
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        g_reg     <= g_next;
        quad_reg  <= quad_next;
        swap_reg  <= swap_next;
        fold3_reg <= fold3_next;
        fold4_reg <= fold3_reg;
        x2_reg    <= x2_next;
        fold_dly_reg[0] <= fold4_reg;
        for (int i = 1; i < CHAIN_LAT; i++)
            fold_dly_reg[i] <= fold_dly_reg[i-1];
        x2_dly_reg[0] <= x2_reg;
        for (int i = 1; i < SIN_SKEW; i++)
            x2_dly_reg[i] <= x2_dly_reg[i-1];
    end

    // cosine chain starts at once, sine chain one cell later so both end together
    assign cos_x2[0] = x2_reg;
    assign cos_t[0]  = Q_ONE;
    assign sin_x2[0] = x2_dly_reg[SIN_SKEW-1];
    assign sin_t[0]  = Q_ONE;

    for (genvar i = 0; i < COS_TERMS; i++)
    begin : g_cos
        prp_series_cell u_cell
        (
            .clk    (clk),
            .x2_in  (cos_x2[i]),
            .t_in   (cos_t[i]),
            .div    (COS_DIV[i]),
            .recip  (COS_RECIP[i]),
            .x2_out (cos_x2[i+1]),
            .t_out  (cos_t[i+1])
        );
    end

    for (genvar i = 0; i < SIN_TERMS; i++)
    begin : g_sin
        prp_series_cell u_cell
        (
            .clk    (clk),
            .x2_in  (sin_x2[i]),
            .t_in   (sin_t[i]),
            .div    (SIN_DIV[i]),
            .recip  (SIN_RECIP[i]),
            .x2_out (sin_x2[i+1]),
            .t_out  (sin_t[i+1])
        );
    end

    always_comb
    begin
        s_prod     = AB_W'(fold_dly_reg[CHAIN_LAT-1].x) * AB_W'(sin_t[SIN_TERMS]);
        s_raw_next = s_prod[Q_FRAC +: Q_W];

        s_rnd = T_W'(s_raw_reg) + ROUND_HALF;
        c_rnd = c_raw_reg + ROUND_HALF;
        s_mag = s_rnd[T_W-1:ROUND_SHIFT];
        c_mag = c_rnd[T_W-1:ROUND_SHIFT];

        // octant folded past 45 degrees swaps sine and cosine
        s0    = swap_o_reg ? c_mag : s_mag;
        c0    = swap_o_reg ? s_mag : c_mag;
        s_pos = $signed({1'b0, s0});
        c_pos = $signed({1'b0, c0});

        case (quad_o_reg)
            QUAD_FIRST:
            begin
                sc_next.sin_v = s_pos;
                sc_next.cos_v = c_pos;
            end
            QUAD_SECOND:
            begin
                sc_next.sin_v = c_pos;
                sc_next.cos_v = -s_pos;
            end
            QUAD_THIRD:
            begin
                sc_next.sin_v = -s_pos;
                sc_next.cos_v = -c_pos;
            end
            default:
            begin
                sc_next.sin_v = -c_pos;
                sc_next.cos_v = s_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_raw_reg  <= s_raw_next;
        c_raw_reg  <= cos_t[COS_TERMS];
        quad_o_reg <= fold_dly_reg[CHAIN_LAT-1].quad;
        swap_o_reg <= fold_dly_reg[CHAIN_LAT-1].swap;
        sc_reg     <= sc_next;
    end

    assign sc = sc_reg;

endmodule

### rtl/core/pivot_rotate_position.sv
// an item's result reaches the ports after the sine/cosine pipe and the product, dot, rotation
//   and saturation registers, with done high for that single cycle, in which it is taken
// the depth comes from the cosine series chain: six cells of three register stages each
// throughput: one item every cycle, busy is held low
// results cannot be held off; the receiver takes each one in the cycle done is high
// reset clears the valid pipe only, so no done appears until items arrive
module pivot_rotate_position
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [prp_pkg::FIELD_W-1:0]  offset_x,
    input  logic signed [prp_pkg::FIELD_W-1:0]  offset_y,
    input  logic signed [prp_pkg::FIELD_W-1:0]  child_pivot_x,
    input  logic signed [prp_pkg::FIELD_W-1:0]  child_pivot_y,
    input  logic signed [prp_pkg::FIELD_W-1:0]  parent_pivot_x,
    input  logic signed [prp_pkg::FIELD_W-1:0]  parent_pivot_y,
    input  logic signed [prp_pkg::FIELD_W-1:0]  position_x,
    input  logic signed [prp_pkg::FIELD_W-1:0]  position_y,
    input  logic signed [prp_pkg::FIELD_W-1:0]  child_angle,
    input  logic signed [prp_pkg::FIELD_W-1:0]  parent_angle,
    output logic                                done,
    output logic signed [prp_pkg::FIELD_W-1:0]  new_position_x,
    output logic signed [prp_pkg::FIELD_W-1:0]  new_position_y,
    output logic signed [prp_pkg::ANGLE_W-1:0]  new_angle
);
    import prp_pkg::*;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [FIELD_W-1:0] px;
        logic signed [FIELD_W-1:0] py;
        logic signed [ANGLE_W-1:0] ang;
    } side_t;

    function automatic logic signed [SAT_W-1:0] sat_coord(input logic signed [POS_W-1:0] v);
        logic signed [SAT_W-1:0] ext;
        ext = SAT_W'(v);
        if (ext > COORD_MAX)
            return COORD_MAX;
        else if (ext < COORD_MIN)
            return COORD_MIN;
        else
            return ext;
    endfunction

    logic                accept;
    logic [PIPE_LAT-1:0] vld_reg;

    side_t   side_reg, side_next;
    side_t   side_dly_reg [SC_LAT-1];
    side_t   side25_reg, side26_reg, side27_reg;
    sincos_t sc;

    logic signed [PROD_W-1:0]  cdx_reg, sdy_reg, sdx_reg, cdy_reg;
    logic signed [DOT_W-1:0]   dotx_reg, doty_reg;
    logic signed [DOT_W-1:0]   dotx_adj, doty_adj;
    logic signed [ROT_W-1:0]   rx_reg, ry_reg, rx_next, ry_next;
    logic signed [POS_W-1:0]   sumx, sumy;
    logic signed [FIELD_W-1:0] npx_reg, npy_reg, npx_next, npy_next;
    logic signed [ANGLE_W-1:0] nang_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_LAT-2:0], accept};
    end

    prp_sincos u_sincos
    (
        .clk   (clk),
        .angle (parent_angle),
        .sc    (sc)
    );

    always_comb
    begin
        side_next.dx  = DELTA_W'(offset_x) - DELTA_W'(parent_pivot_x) + DELTA_W'(child_pivot_x);
        side_next.dy  = DELTA_W'(offset_y) - DELTA_W'(parent_pivot_y) + DELTA_W'(child_pivot_y);
        side_next.px  = position_x;
        side_next.py  = position_y;
        side_next.ang = ANGLE_W'(child_angle) + ANGLE_W'(parent_angle);

        // division by the trig scale truncates toward zero
        dotx_adj = dotx_reg + (dotx_reg[DOT_W-1] ? TRUNC_BIAS : '0);
        doty_adj = doty_reg + (doty_reg[DOT_W-1] ? TRUNC_BIAS : '0);
        rx_next  = $signed(dotx_adj[DOT_W-1:TRIG_FRACTION_BITS]);
        ry_next  = $signed(doty_adj[DOT_W-1:TRIG_FRACTION_BITS]);

        sumx     = POS_W'(side27_reg.px) + POS_W'(rx_reg) - POS_W'(side27_reg.dx);
        sumy     = POS_W'(side27_reg.py) + POS_W'(ry_reg) - POS_W'(side27_reg.dy);
        npx_next = FIELD_W'(sat_coord(sumx));
        npy_next = FIELD_W'(sat_coord(sumy));
    end

    always_ff @(posedge clk)
    begin
        side_reg        <= side_next;
        side_dly_reg[0] <= side_reg;
        for (int i = 1; i < SC_LAT - 1; i++)
            side_dly_reg[i] <= side_dly_reg[i-1];

        cdx_reg    <= PROD_W'(sc.cos_v) * PROD_W'(side_dly_reg[SC_LAT-2].dx);
        sdy_reg    <= PROD_W'(sc.sin_v) * PROD_W'(side_dly_reg[SC_LAT-2].dy);
        sdx_reg    <= PROD_W'(sc.sin_v) * PROD_W'(side_dly_reg[SC_LAT-2].dx);
        cdy_reg    <= PROD_W'(sc.cos_v) * PROD_W'(side_dly_reg[SC_LAT-2].dy);
        side25_reg <= side_dly_reg[SC_LAT-2];

        dotx_reg   <= DOT_W'(cdx_reg) - DOT_W'(sdy_reg);
        doty_reg   <= DOT_W'(sdx_reg) + DOT_W'(cdy_reg);
        side26_reg <= side25_reg;

        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        side27_reg <= side26_reg;

        npx_reg    <= npx_next;
        npy_reg    <= npy_next;
        nang_reg   <= side27_reg.ang;
    end

    assign done           = vld_reg[PIPE_LAT-1];
    assign new_position_x = npx_reg;
    assign new_position_y = npy_reg;
    assign new_angle      = nang_reg;

endmodule
